### design/mpas_pkg.sv
// Shared constants, lookup functions and control structs of the MPEG audio frame scanner.
`timescale 1ns / 1ps
`default_nettype none

package mpas_pkg;

   localparam int COUNT_BITS_DEFAULT = 32;

   localparam logic [7:0]  SYNC_BYTE     = 8'hFF;
   localparam logic [2:0]  SYNC_HIGH     = 3'b111;
   localparam logic [1:0]  LAYER_III     = 2'b01;
   localparam logic [3:0]  IDX_RESERVED  = 4'hF;
   localparam logic [1:0]  FREQ_RESERVED = 2'h3;

   localparam logic [1:0]  VER_MPEG2  = 2'd0;
   localparam logic [1:0]  VER_MPEG1  = 2'd1;
   localparam logic [1:0]  VER_MPEG25 = 2'd2;

   localparam logic [17:0] LEN_FACTOR_V1 = 18'd144000;
   localparam logic [17:0] LEN_FACTOR_V2 = 18'd72000;

   localparam int DIV_STEPS      = 11;
   localparam int DIV_COUNT_BITS = $clog2(DIV_STEPS + 1);

   localparam int          CSR_ADDR_BITS = 3;
   localparam logic        REG_MIN_LEN   = 1'b0;
   localparam logic [10:0] MIN_LEN_RESET = 11'd21;

   typedef struct packed {
      logic step;     // input transaction accepted
      logic div_run;  // advance the length divider one bit
      logic finish;   // close the header and load the result
   } ctrl_cmd_type;

   typedef struct packed {
      logic need_div; // accepted byte completes a header that passed the code checks
      logic div_done; // divider is on its final step
   } ctrl_status_type;

   // Layer III bitrate in kbit/s; MPEG2.5 shares the MPEG2 table.
   function automatic logic [8:0] kbps_lookup(input logic [1:0] ver, input logic [3:0] idx);
      logic [8:0] kbps;
      if (ver == VER_MPEG1) begin
         case (idx)
            4'd1:    kbps = 9'd32;
            4'd2:    kbps = 9'd40;
            4'd3:    kbps = 9'd48;
            4'd4:    kbps = 9'd56;
            4'd5:    kbps = 9'd64;
            4'd6:    kbps = 9'd80;
            4'd7:    kbps = 9'd96;
            4'd8:    kbps = 9'd112;
            4'd9:    kbps = 9'd128;
            4'd10:   kbps = 9'd160;
            4'd11:   kbps = 9'd192;
            4'd12:   kbps = 9'd224;
            4'd13:   kbps = 9'd256;
            4'd14:   kbps = 9'd320;
            default: kbps = 9'd0;
         endcase
      end else begin
         case (idx)
            4'd1:    kbps = 9'd8;
            4'd2:    kbps = 9'd16;
            4'd3:    kbps = 9'd24;
            4'd4:    kbps = 9'd32;
            4'd5:    kbps = 9'd40;
            4'd6:    kbps = 9'd48;
            4'd7:    kbps = 9'd56;
            4'd8:    kbps = 9'd64;
            4'd9:    kbps = 9'd80;
            4'd10:   kbps = 9'd96;
            4'd11:   kbps = 9'd112;
            4'd12:   kbps = 9'd128;
            4'd13:   kbps = 9'd144;
            4'd14:   kbps = 9'd160;
            default: kbps = 9'd0;
         endcase
      end
      return kbps;
   endfunction

   function automatic logic [15:0] hz_lookup(input logic [1:0] ver, input logic [1:0] fcode);
      logic [15:0] hz;
      case ({ver, fcode})
         {VER_MPEG2, 2'd0}:  hz = 16'd22050;
         {VER_MPEG2, 2'd1}:  hz = 16'd24000;
         {VER_MPEG2, 2'd2}:  hz = 16'd16000;
         {VER_MPEG1, 2'd0}:  hz = 16'd44100;
         {VER_MPEG1, 2'd1}:  hz = 16'd48000;
         {VER_MPEG1, 2'd2}:  hz = 16'd32000;
         {VER_MPEG25, 2'd0}: hz = 16'd11025;
         {VER_MPEG25, 2'd1}: hz = 16'd12000;
         {VER_MPEG25, 2'd2}: hz = 16'd8000;
         default:            hz = 16'd0;
      endcase
      return hz;
   endfunction

endpackage

`default_nettype wire

### design/mpas_csr.sv
// Configuration register file: minimum accepted frame length.
`timescale 1ns / 1ps
`default_nettype none

module mpas_csr (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [mpas_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  wire logic [31:0]                        csr_pwdata,
   output logic      [31:0]                        csr_prdata,
   output logic                                    csr_pready,
   output logic      [10:0]                        min_len_limit
);

   logic [10:0] min_len_ff;
   logic        sel_min;

   assign sel_min    = (csr_paddr[mpas_pkg::CSR_ADDR_BITS-1] == mpas_pkg::REG_MIN_LEN);
   assign csr_pready = 1'b1;
   assign csr_prdata = sel_min ? 32'(min_len_ff) : 32'd0;
   assign min_len_limit = min_len_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_len_ff <= mpas_pkg::MIN_LEN_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready && sel_min) begin
         min_len_ff <= csr_pwdata[10:0];
      end
   end

endmodule

`default_nettype wire

### design/mpas_ctrl.sv
// Controller: sequences byte steps, the length divider and the result register valid.
`timescale 1ns / 1ps
`default_nettype none

module mpas_ctrl (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   output mpas_pkg::ctrl_cmd_type         cmd,
   input  wire mpas_pkg::ctrl_status_type status
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_DIV  = 3'b010,
      ST_FIN  = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;
   logic      load;

   assign req_tready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in    = state_ff;
      cmd.step    = 1'b0;
      cmd.div_run = 1'b0;
      cmd.finish  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            cmd.step = accept;
            if (accept && status.need_div) begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_run = 1'b1;
            if (status.div_done) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            cmd.finish = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign load = (cmd.step && !status.need_div) || cmd.finish;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

### design/mpas_datapath.sv
// Datapath: scan state, header decode, length divider, counters and the result register.
`timescale 1ns / 1ps
`default_nettype none

module mpas_datapath #(
   parameter int COUNT_BITS = mpas_pkg::COUNT_BITS_DEFAULT
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire mpas_pkg::ctrl_cmd_type    cmd,
   output mpas_pkg::ctrl_status_type      status,
   input  wire logic [7:0]                req_tdata,
   input  wire logic                      req_tlast,
   input  wire logic [10:0]               min_len_limit,
   output logic      [111:0]              rsp_tdata,
   output logic                           rsp_tuser,
   output logic                           rsp_tlast
);

   typedef enum logic [2:0] {
      PH_HUNT = 3'b001,
      PH_HEAD = 3'b010,
      PH_SKIP = 3'b100
   } phase_type;

   // scan state
   phase_type              phase_ff, phase_in;
   logic [23:0]            shift_ff, shift_in;
   logic [1:0]             cnt_ff, cnt_in;
   logic [10:0]            skip_ff, skip_in;
   logic                   pending_ff, pending_in;
   logic [COUNT_BITS-1:0]  frames_ff, frames_in;
   logic [COUNT_BITS-1:0]  bad_ff, bad_in;
   logic                   last_ff;

   // divider
   logic [16:0]                         rem_ff;
   logic [10:0]                         quo_ff;
   logic [mpas_pkg::DIV_COUNT_BITS-1:0] steps_ff;

   // result register
   logic        o_found_ff, o_found_in;
   logic [1:0]  o_ver_ff, o_ver_in;
   logic [3:0]  o_idx_ff, o_idx_in;
   logic [8:0]  o_kbps_ff, o_kbps_in;
   logic [15:0] o_hz_ff, o_hz_in;
   logic [10:0] o_len_ff, o_len_in;
   logic        o_pad_ff, o_pad_in;
   logic [1:0]  o_mode_ff, o_mode_in;
   logic [31:0] o_frames_ff;
   logic [31:0] o_bad_ff;
   logic        o_done_ff, o_done_in;

   // decode of the header being completed by the incoming byte
   logic [23:0] shift_n;
   logic [1:0]  ver_n;
   logic [3:0]  idx_n;
   logic        pre_ok_n;
   logic        head_last;
   logic [17:0] factor_n;
   logic [26:0] product_n;

   // decode of the held header
   logic [1:0]  ver_h;
   logic [3:0]  idx_h;
   logic [8:0]  kbps_h;
   logic [15:0] hz_h;
   logic        pad_h;
   logic [1:0]  mode_h;

   logic [16:0] trial;
   logic        fits;
   logic [11:0] len;
   logic        last_c;
   logic        commit;

   assign shift_n  = {shift_ff[15:0], req_tdata};
   assign ver_n    = shift_n[20] ? {1'b0, shift_n[19]} : mpas_pkg::VER_MPEG25;
   assign idx_n    = shift_n[15:12];
   assign pre_ok_n = (shift_n[23:21] == mpas_pkg::SYNC_HIGH)
                     && (shift_n[18:17] == mpas_pkg::LAYER_III)
                     && (idx_n != mpas_pkg::IDX_RESERVED)
                     && (shift_n[11:10] != mpas_pkg::FREQ_RESERVED);
   assign head_last = (phase_ff == PH_HEAD) && (cnt_ff == 2'd2);
   assign factor_n  = (ver_n == mpas_pkg::VER_MPEG1) ? mpas_pkg::LEN_FACTOR_V1
                                                    : mpas_pkg::LEN_FACTOR_V2;
   assign product_n = factor_n * mpas_pkg::kbps_lookup(ver_n, idx_n);

   assign status.need_div = head_last && pre_ok_n;
   assign status.div_done = (steps_ff == mpas_pkg::DIV_COUNT_BITS'(1));

   assign ver_h  = shift_ff[20] ? {1'b0, shift_ff[19]} : mpas_pkg::VER_MPEG25;
   assign idx_h  = shift_ff[15:12];
   assign kbps_h = mpas_pkg::kbps_lookup(ver_h, idx_h);
   assign hz_h   = mpas_pkg::hz_lookup(ver_h, shift_ff[11:10]);
   assign pad_h  = shift_ff[9];
   assign mode_h = shift_ff[7:6];

   // restoring division, one quotient bit per cycle; remainder stays below the divisor
   assign trial = {rem_ff[15:0], quo_ff[10]};
   assign fits  = (trial >= {1'b0, hz_h});
   assign len   = 12'(quo_ff) + 12'(pad_h);

   always_ff @(posedge clock) begin
      if (reset) begin
         steps_ff <= '0;
      end else if (cmd.step && status.need_div) begin
         steps_ff <= mpas_pkg::DIV_COUNT_BITS'(mpas_pkg::DIV_STEPS);
      end else if (cmd.div_run) begin
         steps_ff <= steps_ff - mpas_pkg::DIV_COUNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.step && status.need_div) begin
         rem_ff <= 17'(product_n[26:11]);
         quo_ff <= product_n[10:0];
      end else if (cmd.div_run) begin
         rem_ff <= fits ? (trial - {1'b0, hz_h}) : trial;
         quo_ff <= {quo_ff[9:0], fits};
      end
   end

   always_comb begin
      phase_in   = phase_ff;
      shift_in   = shift_ff;
      cnt_in     = cnt_ff;
      skip_in    = skip_ff;
      pending_in = pending_ff;
      frames_in  = frames_ff;
      bad_in     = bad_ff;
      o_found_in = 1'b0;
      o_ver_in   = '0;
      o_idx_in   = '0;
      o_kbps_in  = '0;
      o_hz_in    = '0;
      o_len_in   = '0;
      o_pad_in   = 1'b0;
      o_mode_in  = '0;
      o_done_in  = 1'b0;

      if (cmd.finish) begin
         last_c = last_ff;
         if ((len != 12'd0) && (len >= 12'(min_len_limit))) begin
            frames_in = (&frames_ff) ? frames_ff : frames_ff + COUNT_BITS'(1);
            if (pending_ff) begin
               bad_in = (&bad_ff) ? bad_ff : bad_ff + COUNT_BITS'(1);
            end
            pending_in = 1'b0;
            o_found_in = 1'b1;
            o_ver_in   = ver_h;
            o_idx_in   = idx_h;
            o_kbps_in  = kbps_h;
            o_hz_in    = hz_h;
            o_len_in   = len[10:0];
            o_pad_in   = pad_h;
            o_mode_in  = mode_h;
            skip_in    = (len > 12'd4) ? 11'(len - 12'd4) : 11'd0;
            phase_in   = (skip_in != 11'd0) ? PH_SKIP : PH_HUNT;
         end else begin
            pending_in = 1'b1;
            phase_in   = PH_HUNT;
         end
      end else begin
         last_c = req_tlast;
         case (phase_ff)
            PH_HEAD: begin
               shift_in = shift_n;
               if (cnt_ff == 2'd2) begin
                  // a header that passes the code checks goes to the divider instead
                  cnt_in     = 2'd0;
                  pending_in = 1'b1;
                  phase_in   = PH_HUNT;
               end else begin
                  cnt_in = cnt_ff + 2'd1;
               end
            end
            PH_SKIP: begin
               if (skip_ff != 11'd0) begin
                  skip_in = skip_ff - 11'd1;
               end
               if (skip_in == 11'd0) begin
                  phase_in = PH_HUNT;
               end
            end
            default: begin
               if (req_tdata == mpas_pkg::SYNC_BYTE) begin
                  phase_in = PH_HEAD;
                  shift_in = '0;
                  cnt_in   = 2'd0;
               end else begin
                  phase_in   = PH_HUNT;
                  pending_in = 1'b1;
               end
            end
         endcase
      end

      // end of stream: close an open header as bad and return to hunting
      if (last_c) begin
         if (phase_in == PH_HEAD) begin
            pending_in = 1'b1;
         end
         if (pending_in) begin
            bad_in = (&bad_in) ? bad_in : bad_in + COUNT_BITS'(1);
         end
         phase_in   = PH_HUNT;
         shift_in   = '0;
         cnt_in     = 2'd0;
         skip_in    = 11'd0;
         pending_in = 1'b0;
         o_done_in  = 1'b1;
      end
   end

   assign commit = cmd.finish || (cmd.step && !status.need_div);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HUNT;
         shift_ff   <= '0;
         cnt_ff     <= 2'd0;
         skip_ff    <= 11'd0;
         pending_ff <= 1'b0;
         frames_ff  <= '0;
         bad_ff     <= '0;
         last_ff    <= 1'b0;
      end else if (commit) begin
         phase_ff   <= phase_in;
         shift_ff   <= shift_in;
         cnt_ff     <= cnt_in;
         skip_ff    <= skip_in;
         pending_ff <= pending_in;
         frames_ff  <= frames_in;
         bad_ff     <= bad_in;
      end else if (cmd.step) begin
         // hold the completed header and the end flag while the length is divided
         shift_ff <= shift_n;
         cnt_ff   <= 2'd0;
         last_ff  <= req_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         o_found_ff  <= o_found_in;
         o_ver_ff    <= o_ver_in;
         o_idx_ff    <= o_idx_in;
         o_kbps_ff   <= o_kbps_in;
         o_hz_ff     <= o_hz_in;
         o_len_ff    <= o_len_in;
         o_pad_ff    <= o_pad_in;
         o_mode_ff   <= o_mode_in;
         o_frames_ff <= 32'(frames_in);
         o_bad_ff    <= 32'(bad_in);
         o_done_ff   <= o_done_in;
      end
   end

   assign rsp_tdata = {3'd0, o_bad_ff, o_frames_ff, o_mode_ff, o_pad_ff, o_len_ff,
                       o_hz_ff, o_kbps_ff, o_idx_ff, o_ver_ff};
   assign rsp_tuser = o_found_ff;
   assign rsp_tlast = o_done_ff;

endmodule

`default_nettype wire

### design/mpeg_audio_frame_scanner.sv
// Top level of the MPEG audio layer III frame scanner.
`timescale 1ns / 1ps
`default_nettype none

// Scans an MPEG audio byte stream, one byte per req transaction, and returns one rsp
// transaction per byte. It hunts for a 0xFF byte, gathers the next three bytes as a
// layer III header, checks sync and reserved codes, decodes version, bitrate and sample
// rate, and computes the frame length; an accepted header (length nonzero and at least
// the minimum length register, register 0 at byte address 0) is reported with
// header_found in tuser and its body is skipped. Counters of accepted frames and
// resynchronizations saturate.
// Throughput is one byte per cycle, except a byte that completes a header passing the
// code checks: it holds off the next byte while the length divider works (a multiply
// into the divider, 11 restoring steps at one quotient bit per cycle, then the header
// is closed). A byte is taken only while the result register is empty or being read in
// the same cycle, so a stalled result side holds off the input.
// No clearing pass after reset.

module mpeg_audio_frame_scanner #(
   parameter int COUNT_BITS = mpas_pkg::COUNT_BITS_DEFAULT
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   input  wire logic [7:0]                         req_tdata,  // [7:0] data_byte
   input  wire logic                               req_tlast,  // last_byte
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // [1:0] mpeg_version, [5:2] bitrate_index, [14:6] bitrate_kbps, [30:15] sample_rate_hz,
   // [41:31] frame_bytes, [42] padding_bit, [44:43] channel_mode, [76:45] frame_total,
   // [108:77] bad_frame_total, [111:109] zero
   output logic      [111:0]                       rsp_tdata,
   output logic                                    rsp_tuser,  // header_found
   output logic                                    rsp_tlast,  // stream_done
   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [mpas_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  wire logic [31:0]                        csr_pwdata,
   output logic      [31:0]                        csr_prdata,
   output logic                                    csr_pready
);

   mpas_pkg::ctrl_cmd_type    cmd;
   mpas_pkg::ctrl_status_type status;
   logic [10:0]               min_len_limit;

   mpas_csr u_csr (
      .clock         (clock),
      .reset         (reset),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready),
      .min_len_limit (min_len_limit)
   );

   mpas_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   mpas_datapath #(
      .COUNT_BITS (COUNT_BITS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_tdata     (req_tdata),
      .req_tlast     (req_tlast),
      .min_len_limit (min_len_limit),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .rsp_tlast     (rsp_tlast)
   );

endmodule

`default_nettype wire

### tb/mpeg_audio_frame_scanner_tb.sv
`timescale 1ns / 1ps
// Self-checking bench of the MPEG audio frame scanner: byte streams in, one checked result per byte.

localparam int unsigned KBPS_MPEG1 [15] = '{0, 32, 40, 48, 56, 64, 80, 96, 112, 128, 160, 192,
                                            224, 256, 320};
localparam int unsigned KBPS_MPEG2 [15] = '{0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112, 128,
                                            144, 160};
// rows follow the version codes: MPEG2, MPEG1, MPEG2.5
localparam int unsigned RATE_HZ [3][3] = '{'{22050, 24000, 16000},
                                           '{44100, 48000, 32000},
                                           '{11025, 12000, 8000}};

typedef enum logic [1:0] {
   SCAN_HUNT   = 2'd0,
   SCAN_HEADER = 2'd1,
   SCAN_SKIP   = 2'd2
} scan_phase_type;

// laid out as rsp_tdata, lowest field last
typedef struct packed {
   logic [2:0]  spare;
   logic [31:0] bad_total;
   logic [31:0] frame_total;
   logic [1:0]  chan_mode;
   logic        pad;
   logic [10:0] frame_len;
   logic [15:0] rate_hz;
   logic [8:0]  kbps;
   logic [3:0]  rate_idx;
   logic [1:0]  version;
} frame_fields_type;

typedef struct packed {
   logic        ok;
   logic [1:0]  version;
   logic [3:0]  rate_idx;
   logic [8:0]  kbps;
   logic [15:0] rate_hz;
   logic [10:0] frame_len;
   logic        pad;
   logic [1:0]  chan_mode;
} header_info_type;

typedef struct packed {
   logic             found;
   logic             done;
   frame_fields_type fields;
} byte_result_type;

class frame_scoreboard;
   logic [10:0]     min_len;
   scan_phase_type  phase;
   logic [23:0]     header;
   logic [1:0]      header_bytes;
   logic [10:0]     skip_left;
   logic            resync;
   logic [31:0]     frames;
   logic [31:0]     bad_frames;
   byte_result_type byte_results[$];
   int              errors;
   int              checked;
   int              headers_taken;

   function new();
      min_len = mpas_pkg::MIN_LEN_RESET;
      phase = SCAN_HUNT;
      header = '0;
      header_bytes = '0;
      skip_left = '0;
      resync = 1'b0;
      frames = '0;
      bad_frames = '0;
      errors = 0;
      checked = 0;
      headers_taken = 0;
   endfunction

   function logic [31:0] bump(logic [31:0] v);
      return (v == '1) ? v : v + 32'd1;
   endfunction

   function header_info_type decode(logic [23:0] h);
      header_info_type info;
      logic [7:0]      b1;
      logic [7:0]      b2;
      int unsigned     kbps;
      int unsigned     hz;
      int unsigned     factor;
      int unsigned     len;
      b1 = h[23:16];
      b2 = h[15:8];
      info = '0;
      info.version = b1[4] ? {1'b0, b1[3]} : mpas_pkg::VER_MPEG25;
      info.rate_idx = b2[7:4];
      info.pad = b2[1];
      info.chan_mode = h[7:6];
      if (b1[7:5] != mpas_pkg::SYNC_HIGH || b1[2:1] != mpas_pkg::LAYER_III ||
          b2[7:4] == mpas_pkg::IDX_RESERVED || b2[3:2] == mpas_pkg::FREQ_RESERVED)
         return info;
      kbps = (info.version == mpas_pkg::VER_MPEG1) ? KBPS_MPEG1[b2[7:4]] : KBPS_MPEG2[b2[7:4]];
      hz = RATE_HZ[info.version][b2[3:2]];
      factor = (info.version == mpas_pkg::VER_MPEG1) ? mpas_pkg::LEN_FACTOR_V1
                                                     : mpas_pkg::LEN_FACTOR_V2;
      len = factor * kbps / hz + info.pad;
      info.kbps = kbps[8:0];
      info.rate_hz = hz[15:0];
      info.frame_len = len[10:0];
      info.ok = (len != 0) && (len >= min_len);
      return info;
   endfunction

   // advance the scanner by one accepted byte and queue its result
   function void note_byte(logic [7:0] d, logic last);
      byte_result_type r;
      header_info_type info;
      r = '0;
      case (phase)
         SCAN_HEADER: begin
            header = {header[15:0], d};
            header_bytes = header_bytes + 2'd1;
            if (header_bytes == 2'd3) begin
               header_bytes = '0;
               info = decode(header);
               if (!info.ok) begin
                  resync = 1'b1;
                  phase = SCAN_HUNT;
               end else begin
                  frames = bump(frames);
                  if (resync)
                     bad_frames = bump(bad_frames);
                  resync = 1'b0;
                  headers_taken++;
                  r.found = 1'b1;
                  r.fields.version = info.version;
                  r.fields.rate_idx = info.rate_idx;
                  r.fields.kbps = info.kbps;
                  r.fields.rate_hz = info.rate_hz;
                  r.fields.frame_len = info.frame_len;
                  r.fields.pad = info.pad;
                  r.fields.chan_mode = info.chan_mode;
                  skip_left = (info.frame_len > 11'd4) ? info.frame_len - 11'd4 : '0;
                  phase = (skip_left != 0) ? SCAN_SKIP : SCAN_HUNT;
               end
            end
         end
         SCAN_SKIP: begin
            if (skip_left != 0)
               skip_left--;
            if (skip_left == 0)
               phase = SCAN_HUNT;
         end
         default: begin
            if (d == mpas_pkg::SYNC_BYTE) begin
               phase = SCAN_HEADER;
               header = '0;
               header_bytes = '0;
            end else begin
               resync = 1'b1;
            end
         end
      endcase
      if (last) begin
         // a header cut short by the stream end counts as a failed one
         if (phase == SCAN_HEADER)
            resync = 1'b1;
         if (resync)
            bad_frames = bump(bad_frames);
         phase = SCAN_HUNT;
         header = '0;
         header_bytes = '0;
         skip_left = '0;
         resync = 1'b0;
         r.done = 1'b1;
      end
      r.fields.frame_total = frames;
      r.fields.bad_total = bad_frames;
      byte_results.push_back(r);
   endfunction

   task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      errors++;
      if (errors <= 30)
         $display("mismatch on result %0d: %s got 0x%0h, want 0x%0h", checked, what, got, want);
   endtask

   task compare(string what, logic [63:0] got, logic [63:0] want);
      if (got !== want)
         report_mismatch(what, got, want);
   endtask

   task check_result(logic [111:0] data, logic user, logic last);
      byte_result_type  want;
      frame_fields_type got;
      checked++;
      if (byte_results.size() == 0) begin
         report_mismatch("result with no byte pending", data[63:0], '0);
         return;
      end
      want = byte_results.pop_front();
      got = data;
      compare("header_found", user, want.found);
      compare("stream_done", last, want.done);
      compare("mpeg_version", got.version, want.fields.version);
      compare("bitrate_index", got.rate_idx, want.fields.rate_idx);
      compare("bitrate_kbps", got.kbps, want.fields.kbps);
      compare("sample_rate_hz", got.rate_hz, want.fields.rate_hz);
      compare("frame_bytes", got.frame_len, want.fields.frame_len);
      compare("padding_bit", got.pad, want.fields.pad);
      compare("channel_mode", got.chan_mode, want.fields.chan_mode);
      compare("frame_total", got.frame_total, want.fields.frame_total);
      compare("bad_frame_total", got.bad_total, want.fields.bad_total);
      compare("tdata fill", got.spare, want.fields.spare);
   endtask
endclass

module mpeg_audio_frame_scanner_tb;

   localparam logic [mpas_pkg::CSR_ADDR_BITS-1:0] MIN_LEN_ADDR = {mpas_pkg::REG_MIN_LEN, 2'b00};

   // {last, byte}: resync noise, a failed header, a short accepted frame cut in its body,
   // a rejected free-bitrate header, stream end inside a header, the longest frame,
   // and a reserved sample-rate code before the stream end
   localparam logic [8:0] OPENING_BYTES [25] = '{
      9'h000, 9'h0FF, 9'h0FF, 9'h010, 9'h000,
      9'h0FF, 9'h0F3, 9'h014, 9'h0C0, 9'h1FF,
      9'h0FF, 9'h0FB, 9'h002, 9'h000, 9'h0FF,
      9'h1E2, 9'h0FF, 9'h0FB, 9'h0EB, 9'h03F,
      9'h155, 9'h0FF, 9'h0FA, 9'h01C, 9'h100
   };

   logic         clock = 1'b0;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [7:0]   req_tdata;
   logic         req_tlast;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [111:0] rsp_tdata;
   logic         rsp_tuser;
   logic         rsp_tlast;
   logic         csr_psel;
   logic         csr_penable;
   logic         csr_pwrite;
   logic [mpas_pkg::CSR_ADDR_BITS-1:0] csr_paddr;
   logic [31:0]  csr_pwdata;
   logic [31:0]  csr_prdata;
   logic         csr_pready;

   int send_idle_pct;
   int recv_stall_pct;
   int rsp_hold_left;
   int bytes_sent;
   int streams_sent;
   int input_stalls;

   frame_scoreboard sb;

   mpeg_audio_frame_scanner uut (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata, .req_tlast,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser, .rsp_tlast,
      .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata, .csr_prdata, .csr_pready
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      #4_000_000;
      $display("timeout with %0d results outstanding", sb.byte_results.size());
      $display("** mpeg_audio_frame_scanner: FAILED **");
      $finish;
   end

   // result side: check each transaction, then pick the next ready
   initial begin
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready)
            sb.check_result(rsp_tdata, rsp_tuser, rsp_tlast);
         if (rsp_hold_left > 0) begin
            rsp_hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
         end
      end
   end

   task automatic send_byte(logic [7:0] d, logic last);
      if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= d;
      req_tlast <= last;
      do begin
         @(posedge clock);
         if (!req_tready)
            input_stalls++;
      end while (!req_tready);
      sb.note_byte(d, last);
      bytes_sent++;
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (sb.byte_results.size() != 0)
         @(posedge clock);
      // a header completion may still be in the length divider
      repeat (20) @(posedge clock);
   endtask

   task automatic write_min_len(logic [10:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= MIN_LEN_ADDR;
      csr_pwdata <= {21'd0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      sb.min_len = value;
   endtask

   // mostly layer III headers with valid sync, biased toward short frames
   function automatic logic [23:0] make_header();
      logic [7:0] b1;
      logic [7:0] b2;
      b1 = 8'($urandom);
      if ($urandom_range(0, 19) != 0)
         b1[7:5] = mpas_pkg::SYNC_HIGH;
      if ($urandom_range(0, 9) != 0)
         b1[2:1] = mpas_pkg::LAYER_III;
      b2 = 8'($urandom);
      if ($urandom_range(0, 2) != 0)
         b2[7:4] = 4'($urandom_range(0, 4));
      if ($urandom_range(0, 7) != 0 && b2[3:2] == mpas_pkg::FREQ_RESERVED)
         b2[3:2] = 2'($urandom_range(0, 2));
      return {b1, b2, 8'($urandom)};
   endfunction

   // one stream, closed early with the stream end once the byte budget is used up
   task automatic send_stream(int stop_at);
      int              n_frames;
      int              pick;
      int              body;
      logic [23:0]     h;
      header_info_type info;
      n_frames = $urandom_range(1, 6);
      streams_sent++;
      for (int f = 0; f < n_frames; f++) begin
         if (bytes_sent >= stop_at)
            break;
         pick = $urandom_range(0, 99);
         if (pick < 10) begin
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom), 1'b0);
         end else if (pick < 18) begin
            // broken header: the next sync byte lands inside it
            send_byte(mpas_pkg::SYNC_BYTE, 1'b0);
            repeat ($urandom_range(1, 2)) send_byte(8'($urandom), 1'b0);
         end
         h = make_header();
         send_byte(mpas_pkg::SYNC_BYTE, 1'b0);
         send_byte(h[23:16], 1'b0);
         send_byte(h[15:8], 1'b0);
         send_byte(h[7:0], 1'b0);
         info = sb.decode(h);
         if (info.ok && info.frame_len > 11'd4) begin
            body = info.frame_len - 4;
            // cut long frames short with the stream end
            if (body > 120) begin
               repeat ($urandom_range(0, 10)) send_byte(8'($urandom), 1'b0);
               break;
            end
            for (int i = 0; i < body && bytes_sent < stop_at; i++)
               send_byte(8'($urandom), 1'b0);
         end
      end
      send_byte(8'($urandom), 1'b1);
   endtask

   task automatic run_phase(logic [10:0] min_len, int send_pct, int recv_pct, bit hold,
                            int target);
      int stop_at;
      drain_results();
      write_min_len(min_len);
      send_idle_pct = send_pct;
      recv_stall_pct = recv_pct;
      // hold off the result side while bytes keep coming, so the input backs up
      if (hold)
         rsp_hold_left = 150;
      stop_at = bytes_sent + target;
      while (bytes_sent < stop_at)
         send_stream(stop_at);
   endtask

   initial begin
      sb = new();
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tlast <= 1'b0;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      rsp_hold_left = 0;
      bytes_sent = 0;
      streams_sent = 0;
      input_stalls = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (OPENING_BYTES[i])
         send_byte(OPENING_BYTES[i][7:0], OPENING_BYTES[i][8]);

      run_phase(11'd0, 0, 0, 1'b0, 105);
      run_phase(11'd1441, 56, 0, 1'b0, 105);
      run_phase(11'd24, 0, 56, 1'b1, 105);
      run_phase(11'($urandom_range(25, 300)), 37, 37, 1'b1, 105);
      run_phase(11'd1, 0, 0, 1'b1, 105);
      drain_results();

      $display("covered %0d bytes in %0d streams, %0d headers accepted, %0d results checked",
               bytes_sent, streams_sent, sb.headers_taken, sb.checked);
      $display("length limits 0 to 1441 under four idle patterns, input held off %0d cycles",
               input_stalls);
      if (sb.errors == 0) begin
         $display("** mpeg_audio_frame_scanner: PASSED **");
      end else begin
         $display("%0d mismatches", sb.errors);
         $display("** mpeg_audio_frame_scanner: FAILED **");
      end
      $finish;
   end

endmodule

### filelist.f
design/mpas_pkg.sv
design/mpas_csr.sv
design/mpas_ctrl.sv
design/mpas_datapath.sv
design/mpeg_audio_frame_scanner.sv
tb/mpeg_audio_frame_scanner_tb.sv
